FILE: src/mfd_pkg.sv
// Package for the mesh forward decision block: constants, field widths and shared types.
// No dependencies.
`timescale 1ns / 1ps
package mfd_pkg;
  localparam logic [31:0] DefaultSeed = 32'h6d2b79f5;
  localparam logic [16:0] CrowdLow    = 17'd6554;
  localparam logic [16:0] CrowdHigh   = 17'd58982;
  localparam logic [16:0] CrowdOne   = 17'd65536;
  localparam logic [15:0] CrowdSpan   = 16'd52428;
  localparam logic [31:0] FullScale   = 32'hFFFFFFFF;
  localparam int unsigned InBytes     = 30;
  localparam int unsigned OutBytes    = 1;

  typedef enum logic [0:0] {
    RegThreshold = 1'b0,
    RegSeed      = 1'b1
  } reg_index_t;

  typedef enum logic [2:0] {
    OpDen   = 3'd0,
    OpNum   = 3'd1,
    OpRhs   = 3'd2,
    OpHigh  = 3'd3,
    OpSqX   = 3'd4,
    OpSqY   = 3'd5,
    OpSqZ   = 3'd6,
    OpThr   = 3'd7
  } op_t;
endpackage

FILE: src/mfd_mul.sv
// Shared 32x32 unsigned multiplier with a registered product.
// Depends on nothing.
`timescale 1ns / 1ps
module mfd_mul (
  input  logic        clk,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [63:0] p
);
  always_ff @(posedge clk) begin
    p <= {32'b0, a} * {32'b0, b};
  end
endmodule

FILE: src/mesh_forward_decision_top.sv
// Mesh forward decision: takes a packet beat, returns one forward flag beat.
// The forward flag is registered after eight passes through the shared
// multiplier and a decision step; a ttl-zero beat skips both.
// A new beat is taken only in the idle state, once the last result is loaded;
// a stalled result holds the decision in the block until the output drains.
// Synchronous active-high reset: generator word 0x6d2b79f5, threshold 0, idle.
// Depends on mfd_pkg and mfd_mul.
`timescale 1ns / 1ps
module mesh_forward_decision_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // ttl, crowding, neighbor_count, hop_location_valid, own_location_valid,
  // own_x, own_y, own_z, hop_x, hop_y, hop_z, zero pad
  input  logic [mfd_pkg::InBytes*8-1:0]     s_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // forward, zero pad
  output logic [mfd_pkg::OutBytes*8-1:0]    m_tdata,
  input  logic                              cfg_we,
  input  logic [0:0]                        cfg_index,
  input  logic [31:0]                       cfg_data
);
  typedef enum logic [1:0] {IDLE, RUN, DONE} state_t;

  state_t             state;
  logic [3:0]         step;
  logic [31:0]        rng_word;
  logic signed [31:0] threshold;
  logic               forward;
  logic               decision;
  logic               out_load;

  logic [15:0] n_r;
  logic [15:0] c_diff, n_m2;
  logic        c_low, c_high, r_full, prox_skip;
  logic [31:0] dx, dy, dz;
  logic [31:0] den_r;
  logic [63:0] num_r, rhs_r, thr2_r;
  logic [63:0] hi_r;
  logic [65:0] acc;

  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;

  logic [7:0]  in_ttl;
  logic [17:0] in_crowd;
  logic [15:0] in_n, n_eff;
  logic [16:0] c_clamp;
  logic [31:0] rng_step, r_s1, r_s2;
  logic [32:0] ex, ey, ez;
  logic        crowd_ok, prox_ok;

  assign in_ttl   = s_tdata[7:0];
  assign in_crowd = s_tdata[25:8];
  assign in_n     = s_tdata[41:26];
  assign n_eff    = (in_n == 16'd0) ? 16'd1 : in_n;
  assign c_clamp  = in_crowd[17] ? 17'd0 :
                    (in_crowd[16:0] > mfd_pkg::CrowdOne) ? mfd_pkg::CrowdOne : in_crowd[16:0];

  assign r_s1     = rng_word ^ (rng_word << 13);
  assign r_s2     = r_s1 ^ (r_s1 >> 17);
  assign rng_step = r_s2 ^ (r_s2 << 5);

  assign ex = {s_tdata[171], s_tdata[171:140]} - {s_tdata[75], s_tdata[75:44]};
  assign ey = {s_tdata[203], s_tdata[203:172]} - {s_tdata[107], s_tdata[107:76]};
  assign ez = {s_tdata[235], s_tdata[235:204]} - {s_tdata[139], s_tdata[139:108]};

  assign s_tready = (state == IDLE);
  assign out_load = (state == DONE) && (step != 4'd9) && (!m_tvalid || m_tready);

  always_comb begin
    mul_a = 32'd0;
    mul_b = 32'd0;
    case (mfd_pkg::op_t'(step[2:0]))
      mfd_pkg::OpDen: begin
        mul_a = {16'd0, mfd_pkg::CrowdSpan};
        mul_b = {16'd0, n_r};
      end
      mfd_pkg::OpNum: begin
        mul_a = {16'd0, c_diff};
        mul_b = {16'd0, n_m2};
      end
      mfd_pkg::OpRhs: begin
        mul_a = mfd_pkg::FullScale - rng_word - 32'd1;
        mul_b = den_r;
      end
      mfd_pkg::OpHigh: begin
        mul_a = rng_word + 32'd1;
        mul_b = {16'd0, n_r};
      end
      mfd_pkg::OpSqX: begin
        mul_a = dx;
        mul_b = dx;
      end
      mfd_pkg::OpSqY: begin
        mul_a = dy;
        mul_b = dy;
      end
      mfd_pkg::OpSqZ: begin
        mul_a = dz;
        mul_b = dz;
      end
      mfd_pkg::OpThr: begin
        mul_a = threshold;
        mul_b = threshold;
      end
      default: begin
        mul_a = 32'd0;
        mul_b = 32'd0;
      end
    endcase
  end

  mfd_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  always_comb begin
    if (c_low) begin
      crowd_ok = !r_full;
    end else if (r_full) begin
      crowd_ok = 1'b0;
    end else if (c_high) begin
      crowd_ok = hi_r <= {31'd0, mfd_pkg::FullScale, 1'b0};
    end else begin
      crowd_ok = num_r <= rhs_r;
    end
    prox_ok = prox_skip || (acc > {2'b0, thr2_r});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      step      <= 4'd0;
      rng_word  <= mfd_pkg::DefaultSeed;
      threshold <= 32'sd0;
      m_tvalid  <= 1'b0;
      forward   <= 1'b0;
      decision  <= 1'b0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (cfg_we) begin
        case (mfd_pkg::reg_index_t'(cfg_index))
          mfd_pkg::RegThreshold: threshold <= cfg_data;
          mfd_pkg::RegSeed:      rng_word  <= (cfg_data == 32'd0) ? mfd_pkg::DefaultSeed
                                                                  : cfg_data;
          default: ;
        endcase
      end
      case (state)
        IDLE: begin
          if (s_tvalid) begin
            step <= 4'd0;
            if (in_ttl == 8'd0) begin
              decision <= 1'b0;
              state    <= DONE;
            end else begin
              rng_word <= rng_step;
              state    <= RUN;
            end
          end
        end
        RUN: begin
          step <= step + 4'd1;
          case (step)
            4'd1: den_r  <= prod[31:0];
            4'd2: num_r  <= {prod[31:0], 32'd0} - {32'd0, prod[31:0]};
            4'd3: rhs_r  <= prod;
            4'd4: hi_r   <= prod;
            4'd5: acc    <= {2'b0, prod};
            4'd6: acc    <= acc + {2'b0, prod};
            4'd7: acc    <= acc + {2'b0, prod};
            4'd8: begin
              thr2_r <= prod;
              state  <= DONE;
            end
            default: ;
          endcase
        end
        DONE: begin
          if (step == 4'd9) begin
            decision <= crowd_ok && prox_ok;
            step     <= 4'd0;
          end
          if (out_load) begin
            forward <= decision;
            state   <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  // operand capture, no reset needed
  always_ff @(posedge clk) begin
    if (state == IDLE && s_tvalid) begin
      n_r       <= n_eff;
      c_diff    <= c_clamp[15:0] - mfd_pkg::CrowdLow[15:0];
      n_m2      <= n_eff - 16'd2;
      c_low     <= (c_clamp <= mfd_pkg::CrowdLow) || (n_eff <= 16'd2);
      c_high    <= c_clamp >= mfd_pkg::CrowdHigh;
      r_full    <= rng_step == mfd_pkg::FullScale;
      prox_skip <= !(s_tdata[42] && s_tdata[43]) || threshold[31];
      dx        <= ex[32] ? 32'(-ex) : ex[31:0];
      dy        <= ey[32] ? 32'(-ey) : ey[31:0];
      dz        <= ez[32] ? 32'(-ez) : ez[31:0];
    end
  end

  assign m_tdata = {7'd0, forward};
endmodule

FILE: tb/mesh_forward_decision_checker.sv
// Checker for the mesh forward decision block: watches the packet, result and
// register write channels, predicts each forward flag and compares.
// Depends on mfd_pkg.
`timescale 1ns / 1ps
module mesh_forward_decision_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  input  logic                              s_tready,
  input  logic [mfd_pkg::InBytes*8-1:0]     s_tdata,
  input  logic                              m_tvalid,
  input  logic                              m_tready,
  input  logic [mfd_pkg::OutBytes*8-1:0]    m_tdata,
  input  logic                              cfg_we,
  input  logic [0:0]                        cfg_index,
  input  logic [31:0]                       cfg_data,
  output int                                errors,
  output int                                pending,
  output int                                fwd_seen,
  output int                                results_seen
);
  typedef struct packed {
    logic signed [31:0] hop_z, hop_y, hop_x, own_z, own_y, own_x;
    logic               own_valid, hop_valid;
    logic [15:0]        neighbors;
    logic signed [17:0] crowding;
    logic [7:0]         ttl;
  } packet_t;

  logic signed [31:0] min_dist;
  logic [31:0]        gen_word;
  logic               flags_due[$];

  function automatic logic [31:0] xorshift(input logic [31:0] w);
    w = w ^ (w << 13);
    w = w ^ (w >> 17);
    w = w ^ (w << 5);
    return w;
  endfunction

  function automatic logic [63:0] crowd_limit(input logic signed [17:0] cr,
                                              input logic [15:0] nb);
    logic [63:0] c, n, num, den, q, full;
    full = 64'hFFFF_FFFF;
    c = cr < 0 ? 64'd0 : 64'(cr);
    if (c > 65536) c = 65536;
    n = nb == 0 ? 64'd1 : 64'(nb);
    if (c <= 6554 || n <= 2) return full;
    if (c >= 58982) return (full * 2) / n;
    num = full * (c - 6554) * (n - 2);
    den = 64'd52428 * n;
    q = num / den + ((num % den) != 0);
    return full - q;
  endfunction

  function automatic logic near_enough_apart(input packet_t p, input logic signed [31:0] thr);
    logic [65:0] sum;
    logic [63:0] d;
    if (!p.hop_valid || !p.own_valid || thr < 0) return 1'b1;
    sum = 0;
    d = 64'($signed({p.hop_x[31], p.hop_x}) - $signed({p.own_x[31], p.own_x}));
    d = d[32] ? 64'(-$signed(d[32:0])) : 64'(d[32:0]);
    sum += 66'(d * d);
    d = 64'($signed({p.hop_y[31], p.hop_y}) - $signed({p.own_y[31], p.own_y}));
    d = d[32] ? 64'(-$signed(d[32:0])) : 64'(d[32:0]);
    sum += 66'(d * d);
    d = 64'($signed({p.hop_z[31], p.hop_z}) - $signed({p.own_z[31], p.own_z}));
    d = d[32] ? 64'(-$signed(d[32:0])) : 64'(d[32:0]);
    sum += 66'(d * d);
    return sum > 66'(64'(thr) * 64'(thr));
  endfunction

  always @(posedge clk) begin
    packet_t p;
    logic    want;
    if (rst) begin
      min_dist <= 0;
      gen_word <= mfd_pkg::DefaultSeed;
      flags_due.delete();
      errors = 0;
      fwd_seen = 0;
      results_seen = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == mfd_pkg::RegThreshold) min_dist <= cfg_data;
        else if (cfg_index == mfd_pkg::RegSeed)
          gen_word <= cfg_data == 0 ? mfd_pkg::DefaultSeed : cfg_data;
      end
      if (s_tvalid && s_tready) begin
        p = packet_t'(s_tdata[$bits(packet_t)-1:0]);
        want = 1'b0;
        if (p.ttl != 0) begin
          gen_word <= xorshift(gen_word);
          want = 64'(xorshift(gen_word)) < crowd_limit(p.crowding, p.neighbors) &&
                 near_enough_apart(p, min_dist);
        end
        flags_due.push_back(want);
      end
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (flags_due.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result beat forward=%0d", m_tdata[0]);
        end else begin
          want = flags_due.pop_front();
          fwd_seen += m_tdata[0];
          if (m_tdata[0] !== want || m_tdata[7:1] !== 7'd0) begin
            errors++;
            if (errors <= 10)
              $display("forward mismatch: expected %0d got %0h", want, m_tdata);
          end
        end
      end
    end
    pending = flags_due.size();
  end
endmodule

FILE: tb/mesh_forward_decision_top_test.sv
// Top of the mesh forward decision testbench: clock, reset, packet and register
// stimulus, result back-pressure and verdict. Depends on mfd_pkg, the block
// and mesh_forward_decision_checker.
`timescale 1ns / 1ps
module mesh_forward_decision_top_test;
  logic                           clk, rst;
  logic                           s_tvalid, s_tready, m_tvalid, m_tready, cfg_we;
  logic [mfd_pkg::InBytes*8-1:0]  s_tdata;
  logic [mfd_pkg::OutBytes*8-1:0] m_tdata;
  logic [0:0]                     cfg_index;
  logic [31:0]                    cfg_data;
  int                             errors, pending, fwd_seen, results_seen;
  int                             idle_cycles;
  logic                           hold_off;
  bit                             stim_done;

  mesh_forward_decision_top dut (.*);
  mesh_forward_decision_checker checker_i (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic int gap();
    int r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  task automatic send(input logic [7:0] ttl, input logic signed [17:0] cr,
                      input logic [15:0] nb, input logic hv, input logic ov,
                      input logic [191:0] coords);
    int g;
    g = gap();
    if (g != 0) begin
      s_tvalid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    s_tdata  <= {{(mfd_pkg::InBytes*8-236){1'b0}}, coords, ov, hv, nb, cr, ttl};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  task automatic write_reg(input mfd_pkg::reg_index_t idx, input logic [31:0] val);
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (16) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [31:0] coord();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $urandom_range(0, 2000) - 1000;
      2: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  task automatic random_packet(input int near);
    logic [191:0] c;
    logic [31:0]  ox, oy, oz;
    logic signed [17:0] cr;
    ox = coord(); oy = coord(); oz = coord();
    if (near) c = {oz + $urandom_range(0, 40) - 20, oy + $urandom_range(0, 40) - 20,
                   ox + $urandom_range(0, 40) - 20, oz, oy, ox};
    else c = {coord(), coord(), coord(), oz, oy, ox};
    case ($urandom_range(0, 4))
      0: cr = 18'($urandom);
      1: cr = 18'($urandom_range(6000, 60000));
      2: cr = $urandom_range(0, 1) ? 18'sd6554 : 18'sd58982;
      default: cr = 18'($urandom_range(0, 65536));
    endcase
    send($urandom_range(0, 15) == 0 ? 8'd0 : 8'($urandom_range(1, 255)), cr,
         $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 12)),
         $urandom_range(0, 5) != 0, $urandom_range(0, 5) != 0, c);
  endtask

  initial begin
    m_tready = 1'b0;
    hold_off = 1'b0;
    @(negedge clk);
    while (!stim_done) begin
      if (hold_off) begin
        m_tready <= 1'b0;
        repeat (300) @(negedge clk);
        hold_off = 1'b0;
      end
      m_tready <= $urandom_range(0, 2) != 0;
      repeat ($urandom_range(0, 3) == 0 ? gap() : 1) @(negedge clk);
    end
    m_tready <= 1'b1;
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    logic [191:0] far;
    rst = 1'b1; s_tvalid = 1'b0; s_tdata = '0;
    cfg_we = 1'b0; cfg_index = mfd_pkg::RegThreshold; cfg_data = '0;
    stim_done = 0;
    repeat (12) @(negedge clk);
    rst = 1'b0;
    far = {32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000, 32'h80000000};
    // directed
    send(8'd0, 18'sd0, 16'd0, 1'b1, 1'b1, far);
    send(8'd255, 18'sd0, 16'd0, 1'b1, 1'b1, '0);
    send(8'd1, 18'sd0, 16'd5, 1'b1, 1'b1, {32'd0, 32'd0, 32'd1, 96'd0});
    send(8'd1, 18'sh20000, 16'hffff, 1'b0, 1'b1, '0);
    send(8'd1, 18'sd131071, 16'hffff, 1'b1, 1'b0, far);
    send(8'd2, 18'sd6554, 16'd3, 1'b1, 1'b1, far);
    send(8'd3, 18'sd6555, 16'd3, 1'b1, 1'b1, far);
    send(8'd3, 18'sd58981, 16'd100, 1'b1, 1'b1, far);
    send(8'd3, 18'sd58982, 16'd2, 1'b1, 1'b1, far);
    send(8'd3, 18'sd32768, 16'd8, 1'b1, 1'b1, ~far);
    write_reg(mfd_pkg::RegThreshold, 32'h7fffffff);
    send(8'd9, 18'sd0, 16'd1, 1'b1, 1'b1, far);
    send(8'd9, 18'sd0, 16'd1, 1'b1, 1'b1, {96'd0, 32'd0, 32'd0, 32'd0});
    write_reg(mfd_pkg::RegThreshold, 32'h80000000);
    send(8'd9, 18'sd0, 16'd1, 1'b1, 1'b1, '0);
    write_reg(mfd_pkg::RegSeed, 32'hffffffff);
    send(8'd9, 18'sd0, 16'd1, 1'b0, 1'b0, '0);
    write_reg(mfd_pkg::RegSeed, 32'd0);
    send(8'd9, 18'sd65536, 16'd4, 1'b0, 1'b0, '0);
    // a step that lands on the all-ones word is rare; a seed write of zero restores the default seed
    write_reg(mfd_pkg::RegSeed, 32'h0);
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: write_reg(mfd_pkg::RegThreshold, 32'd0);
        1: write_reg(mfd_pkg::RegThreshold, 32'd16);
        2: write_reg(mfd_pkg::RegThreshold, 32'hffffffff);
        3: write_reg(mfd_pkg::RegSeed, $urandom);
        4: write_reg(mfd_pkg::RegThreshold, 32'd2000);
        5: write_reg(mfd_pkg::RegSeed, 32'h1);
        default: write_reg(mfd_pkg::RegThreshold, $urandom);
      endcase
      if (ph == 2) hold_off = 1'b1;
      for (int i = 0; i < 200; i++) random_packet(ph == 1 || ph == 4);
    end
    stim_done = 1;
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    $display("Ran %0d result beats over seven register settings, %0d forwarded.",
             results_seen, fwd_seen);
    if (errors == 0 && pending == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule

FILE: filelist.f
src/mfd_pkg.sv
src/mfd_mul.sv
src/mesh_forward_decision_top.sv
tb/mesh_forward_decision_checker.sv
tb/mesh_forward_decision_top_test.sv
